### hdl/gpf_pkg.sv
`default_nettype none
package gpf_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST_P,
        ST_DIV_P,
        ST_TEST_Q,
        ST_DIV_Q,
        ST_NEXT,
        ST_OUT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture input number
        logic init_p;     // p = 3
        logic step_p;     // p += 2
        logic start_p;    // start primality test on p
        logic start_q;    // start primality test on n - p
        logic div_step;   // one remainder step
        logic set_hit;    // latch pair into result
        logic set_four;   // result 2 + 2
        logic clr_res;    // result all zeros
    } cmd_t;

    typedef struct packed {
        logic n_even_big;  // even and > 4
        logic n_is_four;
        logic p_over;      // p > n/2
        logic div_done;    // test finished
        logic div_prime;   // test verdict
    } sts_t;
endpackage
`default_nettype wire

### hdl/gpf_ctrl.sv
`default_nettype none
module gpf_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_beat,
    input  wire logic         out_beat,
    input  wire gpf_pkg::sts_t sts,
    output gpf_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              res_valid
);
    import gpf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_beat) state_next = ST_CHECK;
            ST_CHECK: begin
                if (sts.n_even_big) state_next = ST_TEST_P;
                else                state_next = ST_OUT;
            end
            ST_TEST_P: begin
                if (sts.p_over) state_next = ST_OUT;
                else            state_next = ST_DIV_P;
            end
            ST_DIV_P: begin
                if (sts.div_done) begin
                    state_next = sts.div_prime ? ST_TEST_Q : ST_NEXT;
                end
            end
            ST_TEST_Q: state_next = ST_DIV_Q;
            ST_DIV_Q: begin
                if (sts.div_done) begin
                    state_next = sts.div_prime ? ST_OUT : ST_NEXT;
                end
            end
            ST_NEXT:   state_next = ST_TEST_P;
            ST_OUT:    if (out_beat) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        busy      = 1'b1;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy     = 1'b0;
                cmd.load = in_beat;
            end
            ST_CHECK: begin
                cmd.init_p   = 1'b1;
                cmd.clr_res  = !sts.n_is_four;
                cmd.set_four = sts.n_is_four;
            end
            ST_TEST_P: cmd.start_p = !sts.p_over;
            ST_DIV_P:  cmd.div_step = !sts.div_done;
            ST_TEST_Q: cmd.start_q = 1'b1;
            ST_DIV_Q: begin
                cmd.div_step = !sts.div_done;
                cmd.set_hit  = sts.div_done && sts.div_prime;
            end
            ST_NEXT:   cmd.step_p = 1'b1;
            ST_OUT:    res_valid = 1'b1;
            default:   busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

### hdl/gpf_dp.sv
`default_nettype none
module gpf_dp #(
    parameter int NUMBER_BITS = 20
) (
    input  wire logic                   aclk,
    input  wire logic [NUMBER_BITS-1:0] number,
    input  wire gpf_pkg::cmd_t          cmd,
    output gpf_pkg::sts_t               sts,
    output logic                        found,
    output logic [18:0]                 smaller_prime,
    output logic [19:0]                 larger_prime
);
    import gpf_pkg::*;

    localparam int NB = NUMBER_BITS;
    localparam int RB = NB + 2;   // wide enough for d*d and remainder

    logic [NB-1:0] n_reg, p_reg;
    logic [NB-1:0] v_reg;          // value under test
    logic [NB-1:0] d_reg;          // odd trial divisor
    logic [RB-1:0] sq_reg;         // d*d, updated incrementally
    logic [NB-1:0] rem_reg;        // v mod d, built one bit a cycle
    logic [$clog2(NB+1)-1:0] bit_reg;
    logic          rem_run_reg, done_reg, prime_reg;
    logic          found_reg;
    logic [18:0]   small_reg;
    logic [19:0]   large_reg;

    logic [NB-1:0] q_val;
    logic [NB:0]   rem_sh;
    logic          trivial_done, trivial_prime;

    assign q_val = n_reg - p_reg;
    assign rem_sh = {rem_reg, v_reg[bit_reg[$clog2(NB+1)-1:0] - 1'b1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) n_reg <= number;
        if (cmd.init_p) p_reg <= NB'(3);
        if (cmd.step_p) p_reg <= p_reg + NB'(2);

        if (cmd.start_p || cmd.start_q) begin
            v_reg       <= cmd.start_p ? p_reg : q_val;
            d_reg       <= NB'(3);
            sq_reg      <= RB'(9);
            rem_reg     <= '0;
            bit_reg     <= ($clog2(NB+1))'(NB);
            rem_run_reg <= 1'b1;
            done_reg    <= 1'b0;
        end else if (cmd.div_step) begin
            if (!rem_run_reg) begin
                // new divisor: check bounds / trivial cases
                if (trivial_done) begin
                    done_reg  <= 1'b1;
                    prime_reg <= trivial_prime;
                end else if (sq_reg > RB'(v_reg)) begin
                    done_reg  <= 1'b1;
                    prime_reg <= 1'b1;
                end else begin
                    rem_run_reg <= 1'b1;
                end
            end else if (bit_reg != '0) begin
                // restoring remainder step
                if (rem_sh >= {1'b0, d_reg}) rem_reg <= NB'(rem_sh - {1'b0, d_reg});
                else                         rem_reg <= rem_sh[NB-1:0];
                bit_reg <= bit_reg - 1'b1;
            end else begin
                if (rem_reg == '0 && !trivial_done && sq_reg <= RB'(v_reg)) begin
                    done_reg  <= 1'b1;
                    prime_reg <= 1'b0;
                end else begin
                    // (d+2)^2 = d^2 + 4d + 4
                    sq_reg      <= sq_reg + {d_reg, 2'b00} + RB'(4);
                    d_reg       <= d_reg + NB'(2);
                    rem_run_reg <= 1'b0;
                end
                rem_reg <= '0;
                bit_reg <= ($clog2(NB+1))'(NB);
            end
        end

        if (cmd.clr_res) begin
            found_reg <= 1'b0; small_reg <= '0; large_reg <= '0;
        end else if (cmd.set_four) begin
            found_reg <= 1'b1; small_reg <= 19'd2; large_reg <= 20'd2;
        end else if (cmd.set_hit) begin
            found_reg <= 1'b1;
            small_reg <= 19'(p_reg);
            large_reg <= 20'(v_reg);
        end
    end

    // below 2 not prime, 2 prime, even not prime
    always_comb begin
        trivial_done  = 1'b0;
        trivial_prime = 1'b0;
        if (v_reg < NB'(2)) begin
            trivial_done = 1'b1;
        end else if (v_reg == NB'(2)) begin
            trivial_done = 1'b1; trivial_prime = 1'b1;
        end else if (!v_reg[0]) begin
            trivial_done = 1'b1;
        end
    end

    assign sts.n_even_big = !n_reg[0] && n_reg > NB'(4);
    assign sts.n_is_four  = n_reg == NB'(4);
    assign sts.p_over     = p_reg > (n_reg >> 1);
    assign sts.div_done   = done_reg;
    assign sts.div_prime  = prime_reg;

    assign found         = found_reg;
    assign smaller_prime = small_reg;
    assign larger_prime  = large_reg;
endmodule
`default_nettype wire

### hdl/goldbach_prime_pair_finder.sv
`default_nettype none
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | number[NUMBER_BITS-1:0], zero pad to bytes
// m_axis  | out | found[0], smaller_prime[19:1], larger_prime[39:20]
//
// One number at a time. Each candidate p costs up to two primality tests (n-p
// is tested only when p is prime); each test walks odd divisors d with
// d*d <= v, and each divisor goes through the bit-serial remainder unit. Odd,
// small and n=4 inputs skip the search and go straight to the result.
// s_tready is high only in idle; the result beat holds on m_tdata until
// taken. Synchronous active-low reset.
module goldbach_prime_pair_finder #(
    parameter int NUMBER_BITS = 20
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((NUMBER_BITS+7)/8)*8-1:0]   s_tdata,  // number
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [39:0]                             m_tdata   // found, smaller, larger
);
    import gpf_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy, res_valid, found;
    logic [18:0] smaller_prime;
    logic [19:0] larger_prime;

    assign s_tready = !busy;
    assign m_tvalid = res_valid;
    assign m_tdata  = {larger_prime, smaller_prime, found};

    gpf_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_beat(s_tvalid && s_tready),
        .out_beat(m_tvalid && m_tready),
        .sts, .cmd, .busy, .res_valid
    );

    gpf_dp #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
        .aclk,
        .number(s_tdata[NUMBER_BITS-1:0]),
        .cmd, .sts, .found, .smaller_prime, .larger_prime
    );
endmodule
`default_nettype wire
